>>> design/csem_pkg.sv
// Shared types and constants for the counting semaphore table.
package csem_pkg;

  localparam int DEF_NUM_ENTRIES = 16;
  localparam logic [31:0] MAX_POS_COUNT = 32'h7FFF_FFFF;

  typedef enum logic [1:0] {
    OP_GET    = 2'd0,
    OP_DELETE = 2'd1,
    OP_SIGNAL = 2'd2,
    OP_WAIT   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_BLOCK     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE  = 2'd0,
    FSM_CMP   = 2'd1,
    FSM_PRI   = 2'd2,
    FSM_APPLY = 2'd3
  } fsm_t;

  // Which per-cell match flag picks the working entry during the update phase.
  typedef enum logic [1:0] {
    SEL_NONE = 2'd0,
    SEL_NAME = 2'd1,
    SEL_FREE = 2'd2,
    SEL_HDL  = 2'd3
  } sel_kind_t;

  typedef struct packed {
    op_t                op;
    logic        [31:0] sem_name;
    logic signed [31:0] init_count;
    logic        [31:0] req_handle;
  } in_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] out_handle;
    logic        wake;
    logic [31:0] wake_name;
  } out_t;

  // Command broadcast from the sequencer to every cell.
  typedef struct packed {
    logic               cmp_en;
    logic               pri_en;
    logic               apply_en;
    sel_kind_t          sel_kind;
    op_t                op;
    logic        [31:0] key_name;
    logic signed [31:0] key_init;
    logic        [31:0] key_handle;
    logic        [31:0] new_handle;
  } cmd_t;

  // Priority chain: set once any lower-numbered cell has the flag.
  typedef struct packed {
    logic name_seen;
    logic hdl_seen;
    logic free_seen;
  } pfx_t;

  // Gather chain: the selected cell ORs its contents in.
  typedef struct packed {
    logic        [31:0] name;
    logic signed [31:0] count;
    logic        [31:0] handle;
  } gat_t;

endpackage

>>> design/csem_cell.sv
// One semaphore entry with its compare, priority and update logic.
module csem_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  csem_pkg::cmd_t cmd,
  input  csem_pkg::pfx_t pfx_in,
  output csem_pkg::pfx_t pfx_out,
  input  csem_pkg::gat_t gat_in,
  output csem_pkg::gat_t gat_out
);

  logic        [31:0] name_r;
  logic signed [31:0] count_r;
  logic        [31:0] handle_r;

  logic name_eq_r;
  logic hdl_eq_r;
  logic free_r;

  logic first_name_r;
  logic first_hdl_r;
  logic first_free_r;

  logic sel;

  always_comb begin
    pfx_out.name_seen = pfx_in.name_seen | name_eq_r;
    pfx_out.hdl_seen  = pfx_in.hdl_seen  | hdl_eq_r;
    pfx_out.free_seen = pfx_in.free_seen | free_r;
  end

  always_comb begin
    case (cmd.sel_kind)
      csem_pkg::SEL_NAME: sel = first_name_r;
      csem_pkg::SEL_FREE: sel = first_free_r;
      csem_pkg::SEL_HDL:  sel = first_hdl_r;
      default:            sel = 1'b0;
    endcase
  end

  always_comb begin
    gat_out.name   = gat_in.name   | (sel ? name_r   : 32'd0);
    gat_out.count  = gat_in.count  | (sel ? count_r  : 32'sd0);
    gat_out.handle = gat_in.handle | (sel ? handle_r : 32'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_eq_r    <= 1'b0;
      hdl_eq_r     <= 1'b0;
      free_r       <= 1'b0;
      first_name_r <= 1'b0;
      first_hdl_r  <= 1'b0;
      first_free_r <= 1'b0;
    end else begin
      if (cmd.cmp_en) begin
        name_eq_r <= (name_r == cmd.key_name);
        hdl_eq_r  <= (handle_r == cmd.key_handle) && (cmd.key_handle != 32'd0);
        free_r    <= (handle_r == 32'd0);
      end
      if (cmd.pri_en) begin
        first_name_r <= name_eq_r & ~pfx_in.name_seen;
        first_hdl_r  <= hdl_eq_r  & ~pfx_in.hdl_seen;
        first_free_r <= free_r    & ~pfx_in.free_seen;
      end
    end
  end

  // Entry contents have a defined reset value, so they are cleared too.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_r   <= 32'd0;
      count_r  <= 32'sd0;
      handle_r <= 32'd0;
    end else if (cmd.apply_en && sel) begin
      case (cmd.op)
        csem_pkg::OP_GET: begin
          // A live entry with the same name is reused untouched.
          if (handle_r == 32'd0) begin
            name_r   <= cmd.key_name;
            count_r  <= cmd.key_init;
            handle_r <= cmd.new_handle;
          end
        end
        csem_pkg::OP_DELETE: begin
          handle_r <= 32'd0;
        end
        csem_pkg::OP_SIGNAL: begin
          if (count_r != csem_pkg::MAX_POS_COUNT) begin
            count_r <= count_r + 32'sd1;
          end
        end
        default: begin
          if (count_r > 32'sd0) begin
            count_r <= count_r - 32'sd1;
          end
        end
      endcase
    end
  end

endmodule

>>> design/counting_semaphore_table.sv
// A request transferred on start is answered by a one-cycle out_valid strobe, registered after
// the compare, priority and update phases; no new request is taken until these are done.
// busy is high in the working phases; the next start is taken while out_valid is shown.
// Reset (rst_n, synchronous, active low) frees every entry, zeroes names and counts, and sets
// the handle counter to one; no clearing pass is needed afterwards.
// The receiver cannot stall: each result is presented for exactly one cycle.
module counting_semaphore_table #(
  parameter int NUM_ENTRIES = csem_pkg::DEF_NUM_ENTRIES
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  csem_pkg::in_t  in_req,
  output logic           out_valid,
  output csem_pkg::out_t out_rsp
);

  // The table is a row of cells, one per entry. Each request runs three phases:
  //   compare:  every cell compares its name and handle with the request and notes
  //             whether it is free;
  //   priority: a prefix chain through the row marks the lowest cell with each flag;
  //   update:   the chosen cell modifies itself, and a gather chain brings its
  //             pre-update contents back here to form the result.

  csem_pkg::fsm_t state_r, state_nxt;
  csem_pkg::in_t  req_r;
  logic [31:0]    handle_cnt_r, handle_cnt_nxt;

  logic any_name_r;
  logic any_hdl_r;
  logic any_free_r;

  logic cmp_en;
  logic pri_en;
  logic apply_en;

  csem_pkg::cmd_t cmd;
  csem_pkg::pfx_t pfx_chain [NUM_ENTRIES+1];
  csem_pkg::gat_t gat_chain [NUM_ENTRIES+1];

  csem_pkg::out_t rsp_nxt;
  csem_pkg::out_t rsp_r;
  logic           out_valid_r;

  logic accept;
  logic creating;

  assign accept = start & ~busy;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      csem_pkg::FSM_IDLE:  if (start) state_nxt = csem_pkg::FSM_CMP;
      csem_pkg::FSM_CMP:   state_nxt = csem_pkg::FSM_PRI;
      csem_pkg::FSM_PRI:   state_nxt = csem_pkg::FSM_APPLY;
      csem_pkg::FSM_APPLY: state_nxt = csem_pkg::FSM_IDLE;
      default:             state_nxt = csem_pkg::FSM_IDLE;
    endcase
  end

  // Phase enables driven by the state.
  always_comb begin
    busy     = 1'b1;
    cmp_en   = 1'b0;
    pri_en   = 1'b0;
    apply_en = 1'b0;
    unique case (state_r)
      csem_pkg::FSM_IDLE:  busy = 1'b0;
      csem_pkg::FSM_CMP:   cmp_en = 1'b1;
      csem_pkg::FSM_PRI:   pri_en = 1'b1;
      csem_pkg::FSM_APPLY: apply_en = 1'b1;
      default:             busy = 1'b1;
    endcase
  end

  // A get reuses the first entry holding the name, else takes the first free entry.
  // Other operations look the entry up by its nonzero handle.
  always_comb begin
    cmd.cmp_en   = cmp_en;
    cmd.pri_en   = pri_en;
    cmd.apply_en = apply_en;
    if (req_r.op == csem_pkg::OP_GET) begin
      if (any_name_r) begin
        cmd.sel_kind = csem_pkg::SEL_NAME;
      end else if (any_free_r) begin
        cmd.sel_kind = csem_pkg::SEL_FREE;
      end else begin
        cmd.sel_kind = csem_pkg::SEL_NONE;
      end
    end else begin
      cmd.sel_kind = any_hdl_r ? csem_pkg::SEL_HDL : csem_pkg::SEL_NONE;
    end
    cmd.op         = req_r.op;
    cmd.key_name   = req_r.sem_name;
    cmd.key_init   = req_r.init_count;
    cmd.key_handle = req_r.req_handle;
    cmd.new_handle = handle_cnt_r;
  end

  assign pfx_chain[0] = '0;
  assign gat_chain[0] = '0;

  for (genvar g = 0; g < NUM_ENTRIES; g++) begin : g_cell
    csem_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd),
      .pfx_in  (pfx_chain[g]),
      .pfx_out (pfx_chain[g+1]),
      .gat_in  (gat_chain[g]),
      .gat_out (gat_chain[g+1])
    );
  end

  // Result formation from the gathered entry during the update phase.
  always_comb begin
    rsp_nxt  = '0;
    creating = 1'b0;
    if (req_r.op == csem_pkg::OP_GET) begin
      if (cmd.sel_kind == csem_pkg::SEL_NONE) begin
        rsp_nxt.status = csem_pkg::ST_FULL;
      end else if (gat_chain[NUM_ENTRIES].handle != 32'd0) begin
        rsp_nxt.out_handle = gat_chain[NUM_ENTRIES].handle;
      end else begin
        rsp_nxt.out_handle = handle_cnt_r;
        creating           = 1'b1;
      end
    end else if (cmd.sel_kind == csem_pkg::SEL_NONE) begin
      rsp_nxt.status = csem_pkg::ST_NOT_FOUND;
    end else if (req_r.op == csem_pkg::OP_WAIT) begin
      if (gat_chain[NUM_ENTRIES].count <= 32'sd0) begin
        rsp_nxt.status = csem_pkg::ST_BLOCK;
      end
    end else begin
      // Delete and signal both wake the sleepers on the entry's name.
      rsp_nxt.wake      = 1'b1;
      rsp_nxt.wake_name = gat_chain[NUM_ENTRIES].name;
    end
  end

  // The handle counter wraps past all ones straight to one, never to zero.
  always_comb begin
    handle_cnt_nxt = handle_cnt_r + 32'd1;
    if (handle_cnt_nxt == 32'd0) begin
      handle_cnt_nxt = 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= csem_pkg::FSM_IDLE;
      handle_cnt_r <= 32'd1;
      any_name_r   <= 1'b0;
      any_hdl_r    <= 1'b0;
      any_free_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= cmd.apply_en;
      if (cmd.pri_en) begin
        any_name_r <= pfx_chain[NUM_ENTRIES].name_seen;
        any_hdl_r  <= pfx_chain[NUM_ENTRIES].hdl_seen;
        any_free_r <= pfx_chain[NUM_ENTRIES].free_seen;
      end
      if (cmd.apply_en && creating) begin
        handle_cnt_r <= handle_cnt_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req;
    end
    if (cmd.apply_en) begin
      rsp_r <= rsp_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = rsp_r;

endmodule
